// File: hdl/grid_ray_wall_march_unit_defines.svh
// assertion helpers shared by the ray march block
`ifndef GRID_RAY_WALL_MARCH_UNIT_DEFINES_SVH
`define GRID_RAY_WALL_MARCH_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GRWM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grwm assertion failed");

// next-cycle implication, checked outside reset
`define GRWM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grwm assertion failed");

`endif

// File: hdl/grwm_pkg.sv
`timescale 1ns / 1ps
package grwm_pkg;

    localparam int CELL_LOG2  = 6;
    localparam int FRAC_BITS  = 16;
    localparam int CELLQ_LOG2 = CELL_LOG2 + FRAC_BITS;
    localparam int MAP_ROWS_MAX = 64;
    localparam int MAP_COLS_MAX = 64;
    localparam int POS_W = 48;
    localparam int STEP_CAP = MAP_ROWS_MAX + MAP_COLS_MAX + 2;
    localparam logic [6:0] NUDGE_Q16 = 7'd66;

    localparam logic [1:0] FUNC_WR_TILE = 2'd0;
    localparam logic [1:0] FUNC_WR_LEN  = 2'd1;
    localparam logic [1:0] FUNC_CAST_H  = 2'd2;
    localparam logic [1:0] FUNC_CAST_V  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [27:0]        player_x;
        logic [27:0]        player_y;
        logic signed [31:0] tan_angle;
        logic signed [31:0] cot_angle;
        logic               facing_up;
        logic               facing_left;
        logic [5:0]         tile_row;
        logic [5:0]         tile_col;
        logic               tile_is_wall;
        logic [6:0]         row_len;
    } t_in;

    typedef struct packed {
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic               hit_wall;
        logic               cast_vertical;
    } t_out;

    // one classified item between front and back
    typedef struct packed {
        logic [1:0]              func;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] xs;
        logic signed [POS_W-1:0] ys;
        logic                    up;
        logic                    left;
        logic [5:0]              row;
        logic [5:0]              col;
        logic                    wall;
        logic [6:0]              len;
    } t_cmd;

endpackage

// File: hdl/grwm_fifo.sv
`timescale 1ns / 1ps
module grwm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  grwm_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output grwm_pkg::t_cmd o_data,
    output logic           o_empty
);
    import grwm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       wr_en, rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = wr_en ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = rd_en ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/grwm_front.sv
`timescale 1ns / 1ps
module grwm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  grwm_pkg::t_in  i_in,
    output logic           full,
    output logic           o_q_push,
    output grwm_pkg::t_cmd o_q_data,
    input  logic           i_q_full
);
    import grwm_pkg::*;

    typedef struct packed {
        logic [1:0]         func;
        logic               horiz;
        logic               to_neg;
        logic [28:0]        main0;
        logic [27:0]        base;
        logic signed [29:0] diff;
        logic signed [31:0] k;
        logic               up;
        logic               left;
        logic [5:0]         row;
        logic [5:0]         col;
        logic               wall;
        logic [6:0]         len;
    } t_s1;

    localparam logic [28:0] CELLQ = 29'(1) << CELLQ_LOG2;

    t_s1  r_s1, n_s1;
    logic r_s1_vld, n_s1_vld;
    logic accept;

    logic [27:0]             main_coord;
    logic signed [61:0]      prod;
    logic signed [POS_W-1:0] other, step_k, step_other, step_main, main_ext;

    assign full     = r_s1_vld && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_s1_vld;

    // first grid line on the main axis and the offset to it
    always_comb begin
        n_s1        = r_s1;
        n_s1.func   = i_in.func;
        n_s1.horiz  = (i_in.func == FUNC_CAST_H);
        n_s1.to_neg = n_s1.horiz ? i_in.facing_up : i_in.facing_left;
        main_coord  = n_s1.horiz ? i_in.player_y : i_in.player_x;
        n_s1.main0  = {1'b0, main_coord[27:CELLQ_LOG2], {CELLQ_LOG2{1'b0}}}
                      + (n_s1.to_neg ? 29'd0 : CELLQ);
        n_s1.base   = n_s1.horiz ? i_in.player_x : i_in.player_y;
        n_s1.diff   = $signed({1'b0, n_s1.main0}) - $signed({2'b00, main_coord});
        n_s1.k      = n_s1.horiz ? i_in.cot_angle : i_in.tan_angle;
        n_s1.up     = i_in.facing_up;
        n_s1.left   = i_in.facing_left;
        n_s1.row    = i_in.tile_row;
        n_s1.col    = i_in.tile_col;
        n_s1.wall   = i_in.tile_is_wall;
        n_s1.len    = (i_in.row_len > 7'(MAP_COLS_MAX)) ? 7'(MAP_COLS_MAX) : i_in.row_len;
        n_s1_vld    = accept || (r_s1_vld && i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // floor rounding of the q16 product is an arithmetic shift
    always_comb begin
        prod       = r_s1.diff * r_s1.k;
        other      = $signed({20'd0, r_s1.base}) + POS_W'(prod >>> FRAC_BITS);
        step_k     = {{(POS_W - 32 - CELL_LOG2){r_s1.k[31]}}, r_s1.k, {CELL_LOG2{1'b0}}};
        step_other = r_s1.to_neg ? -step_k : step_k;
        step_main  = r_s1.to_neg ? -$signed({19'd0, CELLQ}) : $signed({19'd0, CELLQ});
        main_ext   = $signed({19'd0, r_s1.main0});

        o_q_data      = '0;
        o_q_data.func = r_s1.func;
        o_q_data.x    = r_s1.horiz ? other : main_ext;
        o_q_data.y    = r_s1.horiz ? main_ext : other;
        o_q_data.xs   = r_s1.horiz ? step_other : step_main;
        o_q_data.ys   = r_s1.horiz ? step_main : step_other;
        o_q_data.up   = r_s1.up;
        o_q_data.left = r_s1.left;
        o_q_data.row  = r_s1.row;
        o_q_data.col  = r_s1.col;
        o_q_data.wall = r_s1.wall;
        o_q_data.len  = r_s1.len;
    end

endmodule

// File: hdl/grwm_back.sv
`timescale 1ns / 1ps
module grwm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [6:0]     i_cfg_wdata,
    input  grwm_pkg::t_cmd i_q_data,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output grwm_pkg::t_out o_out,
    output logic           empty,
    input  logic           pop
);
    import grwm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [6:0] row_len_mem [MAP_ROWS_MAX];
    logic       wall_mem    [MAP_ROWS_MAX * MAP_COLS_MAX];

    logic [1:0]              r_state, n_state;
    logic [6:0]              r_map_rows;
    logic signed [POS_W-1:0] r_x, r_y, r_xs, r_ys, n_x, n_y;
    logic                    r_up, r_left, r_vert, r_hit, n_hit;
    logic [7:0]              r_cnt, n_cnt;
    logic                    r_out_vld, n_out_vld;
    t_out                    r_out;
    logic                    load_out;
    logic [6:0]              r_len_a, r_len_b;
    logic                    r_wall;

    logic [6:0]              rows_sat;
    logic signed [POS_W-1:0] nx, ny;
    logic [5:0]              row, nrow, ncol;
    logic                    off_map, wall_hit, is_cast;

    function automatic logic signed [31:0] sat32(input logic signed [POS_W-1:0] v);
        logic signed [31:0] res;
        if (v > $signed(POS_W'(32'h7fff_ffff))) begin
            res = 32'sh7fff_ffff;
        end else if (v < -$signed(POS_W'(33'h0_8000_0000))) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign empty   = !r_out_vld;
    assign o_out   = r_out;
    assign is_cast = (i_q_data.func == FUNC_CAST_H) || (i_q_data.func == FUNC_CAST_V);
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    // tile addresses of the current crossing, nudged toward the facing side
    always_comb begin
        rows_sat = (r_map_rows > 7'(MAP_ROWS_MAX)) ? 7'(MAP_ROWS_MAX) : r_map_rows;
        nx       = r_x - (r_left ? POS_W'(NUDGE_Q16) : '0);
        ny       = r_y - (r_up ? POS_W'(NUDGE_Q16) : '0);
        row      = r_y[CELLQ_LOG2 +: 6];
        nrow     = ny[POS_W-1] ? 6'd0 : ny[CELLQ_LOG2 +: 6];
        ncol     = nx[POS_W-1] ? 6'd0 : nx[CELLQ_LOG2 +: 6];
        off_map  = r_x[POS_W-1] || r_y[POS_W-1]
                   || (r_y >= $signed({19'd0, rows_sat, {CELLQ_LOG2{1'b0}}}))
                   || (r_x >= $signed({19'd0, r_len_a, {CELLQ_LOG2{1'b0}}}));
        wall_hit = ({1'b0, ncol} < r_len_b) && r_wall;
    end

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_y       = r_y;
        n_cnt     = r_cnt;
        n_hit     = r_hit;
        load_out  = 1'b0;
        n_out_vld = r_out_vld && !pop;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop && is_cast) begin
                    n_x     = i_q_data.x;
                    n_y     = i_q_data.y;
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                priority if (r_cnt == 8'(STEP_CAP) || off_map) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else if (wall_hit) begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_x     = r_x + r_xs;
                    n_y     = r_y + r_ys;
                    n_cnt   = r_cnt + 8'd1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_vld || pop) begin
                    load_out  = 1'b1;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_map_rows <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_map_rows <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_cnt <= n_cnt;
        r_hit <= n_hit;
        if (o_q_pop && is_cast) begin
            r_xs   <= i_q_data.xs;
            r_ys   <= i_q_data.ys;
            r_up   <= i_q_data.up;
            r_left <= i_q_data.left;
            r_vert <= (i_q_data.func == FUNC_CAST_V);
        end
        if (load_out) begin
            r_out.hit_x         <= sat32(r_x);
            r_out.hit_y         <= sat32(r_y);
            r_out.hit_wall      <= r_hit;
            r_out.cast_vertical <= r_vert;
        end
    end

    // map memories, written from the queue head and read through registered ports
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_data.func == FUNC_WR_TILE)) begin
            wall_mem[{i_q_data.row, i_q_data.col}] <= i_q_data.wall;
        end
        if (o_q_pop && (i_q_data.func == FUNC_WR_LEN)) begin
            row_len_mem[i_q_data.row] <= i_q_data.len;
        end
        r_len_a <= row_len_mem[row];
        r_len_b <= row_len_mem[nrow];
        r_wall  <= wall_mem[{nrow, ncol}];
    end

endmodule

// File: hdl/grid_ray_wall_march_unit.sv
`timescale 1ns / 1ps
// grid ray march: finds where a ray first meets a wall tile of a loaded map
// input channel: push/full, one t_in beat per item; func 0 and 1 load a wall
//   bit or a row length, func 2 and 3 cast a ray on horizontal or vertical lines
// result channel: empty/pop, one t_out beat per cast, none per write
// config: i_cfg_we/i_cfg_wdata set the number of map rows, write while idle
// the front stage registers an item, works out the first crossing with one
//   multiply and the per-cell step, and hands it to a two-entry queue
// the back end applies each write as it pops it and marches casts by
//   alternating S_READ for the registered map reads and S_EVAL to test and step
// a cast passes the front register, the queue, an S_READ and S_EVAL pair per
//   crossing tested, S_DONE and the output register; at most 65 crossings on a
//   64 by 64 map; the march loop through the map memories sets the throughput
// reset clears the queue, the control state and the row count; the map
//   contents are not cleared and must be written before a cast reads them
// when the receiver stalls, a finished result waits in the output register
//   while the back end takes the next item; the queue then fills and full rises
module grid_ray_wall_march_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  grwm_pkg::t_in i_in,
    output logic          full,
    output grwm_pkg::t_out o_out,
    output logic          empty,
    input  logic          pop,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata
);
    import grwm_pkg::*;
    `include "grid_ray_wall_march_unit_defines.svh"

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_wdata, q_rdata;

    grwm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_in     (i_in),
        .full     (full),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    grwm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    grwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out       (o_out),
        .empty       (empty),
        .pop         (pop)
    );

    `GRWM_ASSERT_IMP(ast_full_means_stage_held, full, q_push && q_full)
    `GRWM_ASSERT_IMP(ast_pop_only_nonempty, q_pop, !q_empty)
    `GRWM_ASSERT_NXT(ast_result_holds, !empty && !pop, !empty && $stable(o_out))

endmodule

// File: tb/grid_ray_wall_march_unit_tb.sv
`timescale 1ns / 1ps
module grid_ray_wall_march_unit_tb;
    import grwm_pkg::*;

    localparam longint CELLQ = 64'd64 * 64'd65536;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    t_in i_in = '0;
    logic full;
    t_out o_out;
    logic empty;
    logic pop = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [6:0] i_cfg_wdata = '0;

    grid_ray_wall_march_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_in(i_in), .full(full),
        .o_out(o_out), .empty(empty), .pop(pop),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the map and the row count
    bit wall_map [64][64];
    int unsigned row_len_map [64];
    int unsigned rows_cfg = 0;
    t_out hit_queue [$];
    int errors = 0;
    bit quiet = 1'b0;
    bit hold_pop = 1'b0;
    int idle_count = 0;

    function automatic longint mul_q16(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p >>> 16;
        return -(((-p) + 65535) >>> 16);
    endfunction

    function automatic longint cell_index(longint v);
        if (v < 0) return 0;
        return v / CELLQ;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // widest length a row may take; a wider row would reach unwritten tiles
    function automatic int row_cap(int r);
        if (r < 2) return 127;
        if (r < 16) return 8;
        return 0;
    endfunction

    // updates the shadow map; returns 1 with the expected beat for a cast
    function automatic bit march_predict(t_in it, output t_out r);
        longint x, y, xs, ys, px, py, tn, ct, row, nrow, ncol, len, nx, ny, rows;
        bit hit;
        r = '0;
        px = longint'(it.player_x);
        py = longint'(it.player_y);
        tn = longint'(it.tan_angle);
        ct = longint'(it.cot_angle);
        case (it.func)
            FUNC_WR_TILE: begin
                wall_map[it.tile_row][it.tile_col] = it.tile_is_wall;
                return 0;
            end
            FUNC_WR_LEN: begin
                row_len_map[it.tile_row] = (it.row_len > 64) ? 64 : it.row_len;
                return 0;
            end
            FUNC_CAST_H: begin
                y = cell_index(py) * CELLQ;
                if (!it.facing_up) y += CELLQ;
                x = px + mul_q16(y - py, ct);
                ys = it.facing_up ? -CELLQ : CELLQ;
                xs = mul_q16(ys, ct);
            end
            default: begin
                x = cell_index(px) * CELLQ;
                if (!it.facing_left) x += CELLQ;
                y = py + mul_q16(x - px, tn);
                xs = it.facing_left ? -CELLQ : CELLQ;
                ys = mul_q16(xs, tn);
            end
        endcase
        rows = (rows_cfg > 64) ? 64 : rows_cfg;
        hit = 1'b0;
        for (int n = 0; n < MAP_ROWS_MAX + MAP_COLS_MAX + 2; n++) begin
            if (x < 0 || y < 0 || y >= rows * CELLQ) break;
            row = cell_index(y);
            if (row >= 64 || x >= longint'(row_len_map[row]) * CELLQ) break;
            nx = it.facing_left ? x - 66 : x;
            ny = it.facing_up ? y - 66 : y;
            nrow = cell_index(ny);
            ncol = cell_index(nx);
            len = (nrow < 64) ? row_len_map[nrow] : 0;
            if (nrow < 64 && ncol < len && ncol < 64 && wall_map[nrow][ncol]) begin
                hit = 1'b1;
                break;
            end
            x += xs;
            y += ys;
        end
        r.hit_x = sat32(x);
        r.hit_y = sat32(y);
        r.hit_wall = hit;
        r.cast_vertical = (it.func == FUNC_CAST_V);
        return 1;
    endfunction

    task automatic send_item(t_in it);
        t_out r;
        int gap;
        if (!quiet && $urandom_range(99) < 6) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk) push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        if (march_predict(it, r)) hit_queue.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk) push <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_rows(int unsigned v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[6:0];
        @(negedge i_clk) i_cfg_we <= 1'b0;
        rows_cfg = v;
    endtask

    function automatic t_in tile_item(int r, int c, bit w);
        t_in it;
        it = '0;
        it.func = FUNC_WR_TILE;
        it.tile_row = r[5:0];
        it.tile_col = c[5:0];
        it.tile_is_wall = w;
        it.player_x = 28'($urandom);
        it.tan_angle = $urandom;
        return it;
    endfunction

    function automatic t_in len_item(int r, int l);
        t_in it;
        it = '0;
        it.func = FUNC_WR_LEN;
        it.tile_row = r[5:0];
        it.row_len = l[6:0];
        it.cot_angle = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] rand_slope();
        int k;
        logic [31:0] v;
        k = $urandom_range(9);
        case (k)
            0: v = $urandom;
            1: v = 32'h7fffffff;
            2: v = 32'h80000000;
            3: v = 32'h00010000;
            4: v = 32'hffff0000;
            5: v = 32'h0;
            default: begin
                v = $urandom_range(0, 32'h40000);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic t_in cast_item(bit vert);
        t_in it;
        it = '0;
        it.func = vert ? FUNC_CAST_V : FUNC_CAST_H;
        it.player_x = 28'($urandom);
        it.player_y = 28'($urandom);
        // most rays start inside the loaded part of the map
        if ($urandom_range(3) != 0) begin
            it.player_x = 28'($urandom_range(0, 32'h01ffffff));
            it.player_y = 28'($urandom_range(0, 32'h03ffffff));
        end
        it.tan_angle = rand_slope();
        it.cot_angle = rand_slope();
        it.facing_up = 1'($urandom_range(1));
        it.facing_left = 1'($urandom_range(1));
        it.tile_row = 6'($urandom);
        it.tile_col = 6'($urandom);
        it.tile_is_wall = 1'($urandom_range(1));
        it.row_len = 7'($urandom);
        return it;
    endfunction

    // every entry a cast can reach gets a value before any cast runs
    task automatic test_map_load();
        int w;
        quiet = 1'b1;
        for (int r = 0; r < 64; r++) begin
            w = (row_cap(r) > 64) ? 64 : row_cap(r);
            send_item(len_item(r, w));
            for (int c = 0; c < w; c++)
                send_item(tile_item(r, c, $urandom_range(99) < 20));
        end
        quiet = 1'b0;
        set_rows(64);
    endtask

    task automatic test_directed();
        t_in it;
        // corners of the position range, both facings
        for (int k = 0; k < 8; k++) begin
            it = cast_item(k[0]);
            it.player_x = k[1] ? 28'hfffffff : 28'h0;
            it.player_y = k[2] ? 28'hfffffff : 28'h0;
            it.facing_up = k[1];
            it.facing_left = k[2];
            it.tan_angle = k[0] ? 32'h7fffffff : 32'h80000000;
            it.cot_angle = k[1] ? 32'h80000000 : 32'h7fffffff;
            send_item(it);
        end
        // start on a grid line facing up and left: nudged index goes below zero
        it = cast_item(1'b0);
        it.player_x = 28'h0; it.player_y = 28'h0400000;
        it.facing_up = 1'b1; it.facing_left = 1'b1; it.cot_angle = 32'h0;
        send_item(it);
        it.func = FUNC_CAST_V;
        it.tan_angle = 32'h0;
        send_item(it);
        // short rows and an oversized length
        send_item(len_item(5, 3));
        send_item(len_item(6, 0));
        send_item(len_item(0, 127));
        send_item(len_item(1, 65));
        send_item(tile_item(5, 10, 1));
        for (int k = 0; k < 4; k++) begin
            it = cast_item(k[0]);
            it.player_y = 28'h0160000 + 28'(k << 20);
            it.facing_left = 1'b0;
            send_item(it);
        end
        send_item(tile_item(63, 63, 1));
        send_item(tile_item(0, 0, 0));
        set_rows(0);
        send_item(cast_item(1'b0));
        send_item(cast_item(1'b1));
        set_rows(127);
        send_item(cast_item(1'b0));
        send_item(cast_item(1'b1));
    endtask

    task automatic test_random(int n_items);
        int k;
        int r;
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(99);
            if (k < 8) send_item(tile_item($urandom_range(63), $urandom_range(63),
                                           1'($urandom_range(1))));
            else if (k < 12) begin
                r = $urandom_range(63);
                send_item(len_item(r, $urandom_range(row_cap(r))));
            end
            else send_item(cast_item(1'($urandom_range(1))));
        end
    endtask

    task automatic test_full_stall();
        fork
            begin
                hold_pop = 1'b1;
                repeat (500) @(posedge i_clk);
                hold_pop = 1'b0;
            end
            begin
                quiet = 1'b1;
                for (int i = 0; i < 20; i++) send_item(cast_item(1'($urandom_range(1))));
                quiet = 1'b0;
            end
        join
    endtask

    always @(negedge i_clk)
        pop <= !hold_pop && (quiet || $urandom_range(99) >= 6);

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && pop && !empty) begin
            if (hit_queue.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = hit_queue.pop_front();
                if (o_out.hit_x !== e.hit_x) begin
                    $error("hit_x exp %0d got %0d", e.hit_x, o_out.hit_x); errors++;
                end
                if (o_out.hit_y !== e.hit_y) begin
                    $error("hit_y exp %0d got %0d", e.hit_y, o_out.hit_y); errors++;
                end
                if (o_out.hit_wall !== e.hit_wall) begin
                    $error("hit_wall exp %0d got %0d", e.hit_wall, o_out.hit_wall); errors++;
                end
                if (o_out.cast_vertical !== e.cast_vertical) begin
                    $error("cast_vertical exp %0d got %0d", e.cast_vertical,
                           o_out.cast_vertical);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_map_load();
        test_directed();
        set_rows(64);
        test_random(60);
        test_full_stall();
        set_rows($urandom_range(1, 63));
        quiet = 1'b1;
        test_random(40);
        quiet = 1'b0;
        set_rows(1);
        test_random(30);
        set_rows(64);
        test_random(70);
        wait_idle();
        if (hit_queue.size() != 0) errors++;
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/grwm_pkg.sv
hdl/grwm_fifo.sv
hdl/grwm_front.sv
hdl/grwm_back.sv
hdl/grid_ray_wall_march_unit.sv
tb/grid_ray_wall_march_unit_tb.sv
